// ===== hw/rtl/fhts_pkg.sv =====
`timescale 1ns / 1ps

package fhts_pkg;

  // configuration port widths
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  // hop length limits
  localparam int HOP_CNT_W       = 7;
  localparam int MAX_HOP_SAMPLES = 64;

  // input word width
  localparam int FREQ_W = 32;

  // sample counter width
  localparam int COUNT_W = 32;

  // pi in Q30, used to build the sine rom
  localparam longint unsigned PI_Q30 = 64'd3373259426;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SAMPLES_PER_HOP = 8'd0,
    CFG_AMPLITUDE       = 8'd1,
    CFG_OFFSET_REAL     = 8'd2,
    CFG_OFFSET_IMAG     = 8'd3
  } cfg_idx_t;

  // settings the back end uses per sample
  typedef struct packed {
    logic        [14:0] amplitude;
    logic signed [15:0] offset_real;
    logic signed [15:0] offset_imag;
  } cfg_t;

  // one classified hop word in the queue
  typedef struct packed {
    logic signed [FREQ_W-1:0]    freq_word;
    logic        [HOP_CNT_W-1:0] count;
  } hop_t;

endpackage

// ===== hw/rtl/fhts_front.sv =====
`timescale 1ns / 1ps

module fhts_front (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [fhts_pkg::FREQ_W-1:0]    in_freq_word,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic        [fhts_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic        [fhts_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                                  q_full,
  output logic                                  q_push,
  output fhts_pkg::hop_t                        q_data,
  output fhts_pkg::cfg_t                        cfg
);

  logic [fhts_pkg::HOP_CNT_W-1:0] samples_per_hop_r;
  logic [14:0]                    amplitude_r;
  logic signed [15:0]             offset_real_r;
  logic signed [15:0]             offset_imag_r;
  logic [fhts_pkg::HOP_CNT_W-1:0] count;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      samples_per_hop_r <= 7'd16;
      amplitude_r       <= 15'd32767;
      offset_real_r     <= '0;
      offset_imag_r     <= '0;
    end else if (cfg_valid) begin
      case (fhts_pkg::cfg_idx_t'(cfg_index))
        fhts_pkg::CFG_SAMPLES_PER_HOP: samples_per_hop_r <= cfg_data[6:0];
        fhts_pkg::CFG_AMPLITUDE:       amplitude_r       <= cfg_data[14:0];
        fhts_pkg::CFG_OFFSET_REAL:     offset_real_r     <= $signed(cfg_data);
        fhts_pkg::CFG_OFFSET_IMAG:     offset_imag_r     <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // clamp the hop length: zero runs one sample, long hops stop at the max
  always_comb begin
    if (samples_per_hop_r == '0) begin
      count = 7'd1;
    end else if (samples_per_hop_r > 7'(fhts_pkg::MAX_HOP_SAMPLES)) begin
      count = 7'(fhts_pkg::MAX_HOP_SAMPLES);
    end else begin
      count = samples_per_hop_r;
    end
  end

  // accept a word whenever the queue has room
  assign in_ready         = !q_full;
  assign q_push           = in_valid && !q_full;
  assign q_data.freq_word = in_freq_word;
  assign q_data.count     = count;

  assign cfg.amplitude   = amplitude_r;
  assign cfg.offset_real = offset_real_r;
  assign cfg.offset_imag = offset_imag_r;

endmodule

// ===== hw/rtl/fhts_queue.sv =====
`timescale 1ns / 1ps

module fhts_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  fhts_pkg::hop_t push_data,
  input  logic           pop,
  output logic           full,
  output logic           valid,
  output fhts_pkg::hop_t pop_data
);

  fhts_pkg::hop_t entry_r [2];
  logic           wr_ptr_r;
  logic           rd_ptr_r;
  logic [1:0]     fill_r;

  assign full     = (fill_r == 2'd2);
  assign valid    = (fill_r != 2'd0);
  assign pop_data = entry_r[rd_ptr_r];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (push && !pop) begin
        fill_r <= fill_r + 2'd1;
      end else if (pop && !push) begin
        fill_r <= fill_r - 2'd1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== hw/rtl/fhts_back.sv =====
`timescale 1ns / 1ps

module fhts_back #(
  parameter int PHASE_BITS      = 32,
  parameter int TABLE_ADDR_BITS = 10,
  parameter int SAMPLE_BITS     = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  input  fhts_pkg::hop_t                q_data,
  output logic                          q_pop,
  input  fhts_pkg::cfg_t                cfg,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_i_sample,
  output logic signed [SAMPLE_BITS-1:0] out_q_sample,
  output logic                          out_last_of_hop
);

  localparam int TBL_SIZE = 1 << TABLE_ADDR_BITS;
  localparam int QUARTER  = TBL_SIZE / 4;
  localparam int PROD_W   = SAMPLE_BITS + 16;
  localparam int WIDE_W   = SAMPLE_BITS + 18;
  localparam int CW       = fhts_pkg::COUNT_W;
  localparam int FW       = fhts_pkg::FREQ_W;
  localparam int NW       = fhts_pkg::HOP_CNT_W;
  localparam longint SMAX = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
  localparam logic signed [WIDE_W-1:0] SAT_MAX = WIDE_W'(SMAX);
  localparam logic signed [WIDE_W-1:0] SAT_MIN = -SAT_MAX - WIDE_W'(1);

  typedef logic signed [SAMPLE_BITS-1:0] rom_t [TBL_SIZE];

  // shift and subtract long division, only used while building the table
  function automatic longint unsigned div_u64(longint unsigned num, longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // sine over a quarter turn, Q30 taylor series to x^15
  function automatic logic signed [SAMPLE_BITS-1:0] quarter_sine(int unsigned q);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned v;
    longint          sum;
    x    = ((longint'(q) * fhts_pkg::PI_Q30 * 64'd2)
           + (64'd1 << (TABLE_ADDR_BITS - 1))) >> TABLE_ADDR_BITS;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    for (int n = 1; n <= 7; n++) begin
      term = div_u64((term * x2) >> 30, 64'((2 * n) * (2 * n + 1)));
      if (n % 2 == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    v = (longint'(sum) * SMAX + (64'd1 << 29)) >> 30;
    if (v > longint'(SMAX)) begin
      v = SMAX;
    end
    return SAMPLE_BITS'(v);
  endfunction

  // full-turn table from quarter-wave symmetry
  function automatic rom_t build_rom();
    rom_t                          rom;
    int unsigned                   quad;
    int unsigned                   r;
    logic signed [SAMPLE_BITS-1:0] s;
    for (int k = 0; k < TBL_SIZE; k++) begin
      quad = k >> (TABLE_ADDR_BITS - 2);
      r    = k & (QUARTER - 1);
      s    = quad[0] ? quarter_sine(QUARTER - r) : quarter_sine(r);
      rom[k] = quad[1] ? -s : s;
    end
    return rom;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  // scale result back to Q1.15, round half up, add offset, saturate
  function automatic logic signed [SAMPLE_BITS-1:0] scale_sat(
    logic signed [PROD_W-1:0] p,
    logic signed [15:0]       offs
  );
    logic signed [WIDE_W-1:0] w;
    w = WIDE_W'(p) + WIDE_W'(16384);
    w = w >>> 15;
    w = w + WIDE_W'(offs);
    if (w > SAT_MAX) begin
      w = SAT_MAX;
    end else if (w < SAT_MIN) begin
      w = SAT_MIN;
    end
    return w[SAMPLE_BITS-1:0];
  endfunction

  // hop sequencer state
  logic          busy_r;
  logic [FW-1:0] fw_r;
  logic [NW-1:0] n_r;
  logic [NW-1:0] k_r;
  logic [CW-1:0] t_r;

  // pipeline
  logic                          v1_r, v2_r, v3_r;
  logic                          last1_r, last2_r, last3_r;
  logic [PHASE_BITS-1:0]         phase_r;
  logic signed [SAMPLE_BITS-1:0] sin_r, cos_r;
  logic signed [PROD_W-1:0]      prod_i_r, prod_q_r;
  logic                          out_valid_r;
  logic                          out_last_r;
  logic signed [SAMPLE_BITS-1:0] out_i_r, out_q_r;

  logic                       en;
  logic                       issue;
  logic                       last_issue;
  logic [63:0]                prod_u;
  logic [63:0]                corr;
  logic [63:0]                phase_full;
  logic [TABLE_ADDR_BITS-1:0] sin_addr;
  logic [TABLE_ADDR_BITS-1:0] cos_addr;

  // whole pipe moves when the output register can take a word
  assign en         = !out_valid_r || out_ready;
  assign issue      = busy_r && en;
  assign last_issue = issue && (k_r == n_r - NW'(1));
  assign q_pop      = q_valid && (!busy_r || last_issue);

  // phase = sign-extended freq word times counter, kept modulo 2^PHASE_BITS
  assign prod_u     = {32'b0, fw_r} * {32'b0, t_r};
  assign corr       = fw_r[FW-1] ? {t_r, 32'b0} : 64'b0;
  assign phase_full = prod_u - corr;

  assign sin_addr = phase_r[PHASE_BITS-1 -: TABLE_ADDR_BITS];
  assign cos_addr = sin_addr + TABLE_ADDR_BITS'(QUARTER);

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      n_r         <= '0;
      k_r         <= '0;
      t_r         <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        busy_r <= 1'b1;
        n_r    <= q_data.count;
        k_r    <= '0;
      end else if (last_issue) begin
        busy_r <= 1'b0;
      end else if (issue) begin
        k_r <= k_r + NW'(1);
      end
      if (issue) begin
        t_r <= t_r + CW'(1);
      end
      if (en) begin
        v1_r        <= issue;
        v2_r        <= v1_r;
        v3_r        <= v2_r;
        out_valid_r <= v3_r;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (q_pop) begin
      fw_r <= q_data.freq_word;
    end
    if (en) begin
      last1_r    <= last_issue;
      phase_r    <= phase_full[PHASE_BITS-1:0];
      last2_r    <= last1_r;
      sin_r      <= SINE_ROM[sin_addr];
      cos_r      <= SINE_ROM[cos_addr];
      last3_r    <= last2_r;
      prod_i_r   <= $signed({1'b0, cfg.amplitude}) * cos_r;
      prod_q_r   <= $signed({1'b0, cfg.amplitude}) * sin_r;
      out_last_r <= last3_r;
      out_i_r    <= scale_sat(prod_i_r, cfg.offset_real);
      out_q_r    <= scale_sat(prod_q_r, cfg.offset_imag);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_i_sample    = out_i_r;
  assign out_q_sample    = out_q_r;
  assign out_last_of_hop = out_last_r;

endmodule

// ===== hw/rtl/frequency_hopping_tone_source.sv =====
`timescale 1ns / 1ps
// a hop word passes queue and sequencer, then phase, table, product and output registers
// throughput: one phase and so one sample per cycle from the hop sequencer, unless the
//   output stalls; samples_per_hop (16 by default) per hop, no gap between queued hops
// a two-word queue lets the input side accept words while the sample pipe stalls, until full
// reset: synchronous, active low; registers return to defaults, sample counter to zero

module frequency_hopping_tone_source #(
  parameter int PHASE_BITS      = 32,
  parameter int TABLE_ADDR_BITS = 10,
  parameter int SAMPLE_BITS     = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [fhts_pkg::FREQ_W-1:0]     in_freq_word,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [SAMPLE_BITS-1:0]          out_i_sample,
  output logic signed [SAMPLE_BITS-1:0]          out_q_sample,
  output logic                                   out_last_of_hop,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic        [fhts_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic        [fhts_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic           q_full;
  logic           q_push;
  logic           q_pop;
  logic           q_valid;
  fhts_pkg::hop_t q_in;
  fhts_pkg::hop_t q_out;
  fhts_pkg::cfg_t cfg;

  // register file and input classification
  fhts_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_freq_word (in_freq_word),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_data       (q_in),
    .cfg          (cfg)
  );

  // hop word queue
  fhts_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .full      (q_full),
    .valid     (q_valid),
    .pop_data  (q_out)
  );

  // sample generator
  fhts_back #(
    .PHASE_BITS      (PHASE_BITS),
    .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
    .SAMPLE_BITS     (SAMPLE_BITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_data          (q_out),
    .q_pop           (q_pop),
    .cfg             (cfg),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_i_sample    (out_i_sample),
    .out_q_sample    (out_q_sample),
    .out_last_of_hop (out_last_of_hop)
  );

endmodule

// ===== hw/rtl/fhts_checker.sv =====
`timescale 1ns / 1ps

module fhts_checker #(
  parameter int SAMPLE_BITS = 16
) (
  input logic                                   clk,
  input logic                                   rst_n,
  input logic                                   in_valid,
  input logic                                   in_ready,
  input logic signed [fhts_pkg::FREQ_W-1:0]     in_freq_word,
  input logic                                   out_valid,
  input logic                                   out_ready,
  input logic signed [SAMPLE_BITS-1:0]          out_i_sample,
  input logic signed [SAMPLE_BITS-1:0]          out_q_sample,
  input logic                                   out_last_of_hop,
  input logic                                   cfg_valid,
  input logic                                   cfg_ready
);

  // a stalled sample word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_i_sample)
      && $stable(out_q_sample) && $stable(out_last_of_hop))
    else $error("stalled output word changed");

  // a waiting hop word holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_freq_word))
    else $error("waiting input word changed");

  // reset empties the sample pipe
  a_reset_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // reset empties the queue, so input is ready right after
  a_reset_in: assert property (@(posedge clk) !rst_n |=> in_ready)
    else $error("input not ready after reset");

  // configuration writes are never refused
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration write stalled");

endmodule

bind frequency_hopping_tone_source fhts_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_fhts_checker (.*);
